// File: hdl/heading_to_differential_drive_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading to differential drive block
// Shared property wrappers so that every check has the same clocking.
// ----------------------------------------------------------------------------
`ifndef HEADING_TO_DIFFERENTIAL_DRIVE_ASSERT_SVH
`define HEADING_TO_DIFFERENTIAL_DRIVE_ASSERT_SVH

// Overlapping implication, checking is off while reset is high.
`define HDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: overlapping implication");

// Next-cycle implication, checked during reset as well.
`define HDD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/hdd_pkg.sv
// ----------------------------------------------------------------------------
// hdd_pkg
// Types and constants shared by the heading to differential drive modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hdd_pkg;

   localparam int HEADING_W = 9;
   localparam int SPEED_W   = 16;
   localparam int N_W       = 6;
   localparam int PROD_W    = SPEED_W + N_W;

   // Heading limits in degrees, one bit wider than the heading port.
   localparam logic signed [HEADING_W:0] DEG_45  = 10'sd45;
   localparam logic signed [HEADING_W:0] DEG_90  = 10'sd90;
   localparam logic signed [HEADING_W:0] DEG_135 = 10'sd135;
   localparam logic signed [HEADING_W:0] DEG_180 = 10'sd180;

   // Division by 45 as a multiplication by a rounded-up reciprocal.
   localparam int RECIP_SHIFT = PROD_W + N_W;
   localparam int RECIP_W     = RECIP_SHIFT - 5;
   localparam logic [RECIP_W-1:0] RECIP_45 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd44) / 64'd45);
   localparam int WIDE_W = PROD_W + RECIP_W;

   // Direction codes.
   localparam logic [1:0] DIR_FWD  = 2'd2;
   localparam logic [1:0] DIR_BACK = 2'd1;

   typedef struct packed {
      logic [N_W-1:0] n;
      logic           scale_left;
      logic           scale_right;
      logic           left_fwd;
      logic           right_fwd;
   } sector_type;

endpackage

`default_nettype wire

// File: hdl/hdd_decode.sv
// ----------------------------------------------------------------------------
// hdd_decode
// Finds the 45-degree sector of a heading, the ramp position within it,
// which wheel is scaled and the direction of each wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module hdd_decode (
   input  wire logic signed [hdd_pkg::HEADING_W-1:0] heading,
   output hdd_pkg::sector_type                       sector
);

   logic signed [hdd_pkg::HEADING_W:0] hx;
   logic signed [hdd_pkg::HEADING_W:0] nx;

   assign hx = {heading[hdd_pkg::HEADING_W-1], heading};

   always_comb begin
      nx                 = '0;
      sector.scale_left  = 1'b0;
      sector.scale_right = 1'b0;
      sector.left_fwd    = (hx > -hdd_pkg::DEG_45) && (hx <= hdd_pkg::DEG_135);
      sector.right_fwd   = (hx > -hdd_pkg::DEG_135) && (hx <= hdd_pkg::DEG_45);
      if (hx > -hdd_pkg::DEG_180 && hx <= -hdd_pkg::DEG_135) begin
         nx                 = -hx - hdd_pkg::DEG_135;
         sector.scale_right = 1'b1;
      end else if (hx > -hdd_pkg::DEG_135 && hx <= -hdd_pkg::DEG_90) begin
         nx                 = hx + hdd_pkg::DEG_135;
         sector.scale_right = 1'b1;
      end else if (hx > -hdd_pkg::DEG_90 && hx <= -hdd_pkg::DEG_45) begin
         nx                = -hx - hdd_pkg::DEG_45;
         sector.scale_left = 1'b1;
      end else if (hx > -hdd_pkg::DEG_45 && hx <= 10'sd0) begin
         nx                = hx + hdd_pkg::DEG_45;
         sector.scale_left = 1'b1;
      end else if (hx > 10'sd0 && hx <= hdd_pkg::DEG_45) begin
         nx                 = hdd_pkg::DEG_45 - hx;
         sector.scale_right = 1'b1;
      end else if (hx > hdd_pkg::DEG_45 && hx <= hdd_pkg::DEG_90) begin
         nx                 = hx - hdd_pkg::DEG_45;
         sector.scale_right = 1'b1;
      end else if (hx > hdd_pkg::DEG_90 && hx <= hdd_pkg::DEG_135) begin
         nx                = hdd_pkg::DEG_135 - hx;
         sector.scale_left = 1'b1;
      end else if (hx > hdd_pkg::DEG_135 && hx <= hdd_pkg::DEG_180) begin
         nx                = hx - hdd_pkg::DEG_135;
         sector.scale_left = 1'b1;
      end
      // Within any sector the ramp position stays in 0..45.
      sector.n = nx[hdd_pkg::N_W-1:0];
   end

endmodule

`default_nettype wire

// File: hdl/hdd_div45.sv
// ----------------------------------------------------------------------------
// hdd_div45
// Exact floor division of the speed-times-ramp product by 45.
// ----------------------------------------------------------------------------
`default_nettype none

module hdd_div45 (
   input  wire logic [hdd_pkg::PROD_W-1:0]  prod,
   output logic      [hdd_pkg::SPEED_W-1:0] quot
);

   logic [hdd_pkg::WIDE_W-1:0] wide;

   // The reciprocal is rounded up with enough fraction bits that the
   // truncated result is exact for every product below 2^PROD_W.
   assign wide = hdd_pkg::WIDE_W'(prod) * hdd_pkg::WIDE_W'(hdd_pkg::RECIP_45);
   assign quot = wide[hdd_pkg::RECIP_SHIFT +: hdd_pkg::SPEED_W];

endmodule

`default_nettype wire

// File: hdl/heading_to_differential_drive.sv
// ----------------------------------------------------------------------------
// heading_to_differential_drive
// Maps a heading and a base speed to left and right wheel commands.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// The block is fully pipelined, so busy is held low and a new request may be
// issued in every cycle. Each request carries a signed heading in degrees
// and an unsigned base speed.
// The result appears on the rsp_ ports after the input, product and result
// registers and is marked by rsp_valid for exactly one cycle. The receiver
// cannot stall the block, so it must capture the result in that cycle.
// Throughput is one request per cycle. The pipeline is: input register,
// sector decode plus the speed-by-ramp multiply, then the divide by 45 done
// as a reciprocal multiply into the result register. Each multiplier sits
// alone between two register stages.
// A synchronous reset clears the pipeline valid bits, so no result is
// strobed for requests in flight at reset. The payload registers are not
// reset. One wheel always runs at the base speed; for headings in -179..180 the
// other is scaled by floor(speed * n / 45), n the position within its sector.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heading_to_differential_drive_assert.svh"

module heading_to_differential_drive (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [hdd_pkg::HEADING_W-1:0] req_heading,
   input  wire logic        [hdd_pkg::SPEED_W-1:0]   req_base_speed,
   output logic                                      rsp_valid,
   output logic             [hdd_pkg::SPEED_W-1:0]   rsp_left_speed,
   output logic             [1:0]                    rsp_left_dir_code,
   output logic             [hdd_pkg::SPEED_W-1:0]   rsp_right_speed,
   output logic             [1:0]                    rsp_right_dir_code,
   output logic                                      rsp_reversing
);

   // Stage 1: captured request.
   logic                                 in_valid_ff;
   logic signed [hdd_pkg::HEADING_W-1:0] in_heading_ff;
   logic        [hdd_pkg::SPEED_W-1:0]   in_speed_ff;

   // Stage 2: decoded sector and the speed-by-ramp product.
   hdd_pkg::sector_type                  sector;
   logic                                 mul_valid_ff;
   hdd_pkg::sector_type                  mul_sector_ff;
   logic        [hdd_pkg::SPEED_W-1:0]   mul_speed_ff;
   logic        [hdd_pkg::PROD_W-1:0]    mul_prod_ff;
   logic        [hdd_pkg::PROD_W-1:0]    mul_prod_in;

   // Stage 3: result register.
   logic        [hdd_pkg::SPEED_W-1:0]   quot;
   logic                                 out_valid_ff;
   logic        [hdd_pkg::SPEED_W-1:0]   out_left_ff;
   logic        [hdd_pkg::SPEED_W-1:0]   out_right_ff;
   logic        [1:0]                    out_left_dir_ff;
   logic        [1:0]                    out_right_dir_ff;
   logic                                 out_rev_ff;

   logic accept;

   // Every stage advances each cycle, so the block never refuses a request.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= accept;
         mul_valid_ff <= in_valid_ff;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_heading_ff <= req_heading;
      in_speed_ff   <= req_base_speed;
   end

   hdd_decode u_decode (
      .heading (in_heading_ff),
      .sector  (sector)
   );

   assign mul_prod_in = hdd_pkg::PROD_W'(in_speed_ff) * hdd_pkg::PROD_W'(sector.n);

   always_ff @(posedge clock) begin
      mul_sector_ff <= sector;
      mul_speed_ff  <= in_speed_ff;
      mul_prod_ff   <= mul_prod_in;
   end

   hdd_div45 u_div45 (
      .prod (mul_prod_ff),
      .quot (quot)
   );

   // The scaled wheel takes the quotient; the other keeps the base speed.
   always_ff @(posedge clock) begin
      out_left_ff      <= mul_sector_ff.scale_left  ? quot : mul_speed_ff;
      out_right_ff     <= mul_sector_ff.scale_right ? quot : mul_speed_ff;
      out_left_dir_ff  <= mul_sector_ff.left_fwd  ? hdd_pkg::DIR_FWD : hdd_pkg::DIR_BACK;
      out_right_dir_ff <= mul_sector_ff.right_fwd ? hdd_pkg::DIR_FWD : hdd_pkg::DIR_BACK;
      out_rev_ff       <= !mul_sector_ff.left_fwd && !mul_sector_ff.right_fwd;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_speed     = out_left_ff;
   assign rsp_right_speed    = out_right_ff;
   assign rsp_left_dir_code  = out_left_dir_ff;
   assign rsp_right_dir_code = out_right_dir_ff;
   assign rsp_reversing      = out_rev_ff;

   // A taken request is strobed out after the input, product and result registers.
   `HDD_ASSERT_IMPL(a_latency, clock, reset, accept, ##3 rsp_valid)
   // Reset leaves no result strobe behind.
   `HDD_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)
   // Reversing is only flagged with both wheels backward.
   `HDD_ASSERT_IMPL(a_rev_dirs, clock, reset, rsp_valid && rsp_reversing,
      rsp_left_dir_code == hdd_pkg::DIR_BACK && rsp_right_dir_code == hdd_pkg::DIR_BACK)
   // At least one wheel carries the base speed of the matching request.
   `HDD_ASSERT_IMPL(a_base_wheel, clock, reset, rsp_valid,
      rsp_left_speed == $past(req_base_speed, 3) || rsp_right_speed == $past(req_base_speed, 3))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the heading to differential drive block
// Sends heading and speed requests, predicts each wheel command and checks
// every strobed result against the prediction, in order.
// ----------------------------------------------------------------------------

module tb_top;

   // Degrees per sector: the ramped wheel runs at speed * n / SECTOR_DEG.
   localparam int SECTOR_DEG    = 45;
   // Extra wait after the last result before the verdict.
   localparam int DRAIN_CYCLES  = 10;
   // Cycles without any accepted request or result before giving up.
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_COUNT  = 400;
   localparam int IDLE_PCT      = 25;
   // Requests in this range of the issue count go out without any idle gap.
   localparam int QUIET_FIRST   = 200;
   localparam int QUIET_LAST    = 300;

   typedef struct packed {
      logic signed [hdd_pkg::HEADING_W-1:0] heading;
      logic        [hdd_pkg::SPEED_W-1:0]   base_speed;
   } drive_request_type;

   typedef struct packed {
      logic [hdd_pkg::SPEED_W-1:0] left_speed;
      logic [1:0]                  left_dir_code;
      logic [hdd_pkg::SPEED_W-1:0] right_speed;
      logic [1:0]                  right_dir_code;
      logic                        reversing;
   } wheel_cmd_type;

   logic                                 clock          = 1'b0;
   logic                                 reset          = 1'b1;
   logic                                 start          = 1'b0;
   logic signed [hdd_pkg::HEADING_W-1:0] req_heading    = '0;
   logic        [hdd_pkg::SPEED_W-1:0]   req_base_speed = '0;
   logic                                 busy;
   logic                                 rsp_valid;
   logic        [hdd_pkg::SPEED_W-1:0]   rsp_left_speed;
   logic        [1:0]                    rsp_left_dir_code;
   logic        [hdd_pkg::SPEED_W-1:0]   rsp_right_speed;
   logic        [1:0]                    rsp_right_dir_code;
   logic                                 rsp_reversing;

   drive_request_type pending_requests[$];
   wheel_cmd_type     expected_cmds[$];
   logic              req_taken      = 1'b0;
   int                issued_count   = 0;
   int                mismatch_count = 0;
   int                stall_cycles   = 0;

   heading_to_differential_drive dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_heading        (req_heading),
      .req_base_speed     (req_base_speed),
      .rsp_valid          (rsp_valid),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_left_dir_code  (rsp_left_dir_code),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_right_dir_code (rsp_right_dir_code),
      .rsp_reversing      (rsp_reversing)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Ramped wheel speed, floor(speed * n / 45), in exact integer arithmetic.
   function automatic logic [hdd_pkg::SPEED_W-1:0] ramp_speed(
      logic [hdd_pkg::SPEED_W-1:0] speed, int n);
      int unsigned product;
      product = int'(speed) * n;
      return hdd_pkg::SPEED_W'(product / SECTOR_DEG);
   endfunction

   // Wheel command for one request. The heading circle is cut into eight
   // sectors; in each one wheel keeps the base speed while the other ramps
   // with the position inside the sector. Headings at or below -180, and
   // the out-of-range ones above 180, leave both wheels at base speed.
   function automatic wheel_cmd_type predict_wheel_cmd(drive_request_type req);
      wheel_cmd_type cmd;
      int            h;
      bit            left_fwd;
      bit            right_fwd;
      h = int'(req.heading);
      cmd.left_speed  = req.base_speed;
      cmd.right_speed = req.base_speed;
      left_fwd  = (h > -45) && (h <= 135);
      right_fwd = (h > -135) && (h <= 45);
      if (h > -180 && h <= -135) begin
         cmd.right_speed = ramp_speed(req.base_speed, -h - 135);
      end else if (h > -135 && h <= -90) begin
         cmd.right_speed = ramp_speed(req.base_speed, h + 135);
      end else if (h > -90 && h <= -45) begin
         cmd.left_speed = ramp_speed(req.base_speed, -h - 45);
      end else if (h > -45 && h <= 0) begin
         cmd.left_speed = ramp_speed(req.base_speed, h + 45);
      end else if (h > 0 && h <= 45) begin
         cmd.right_speed = ramp_speed(req.base_speed, 45 - h);
      end else if (h > 45 && h <= 90) begin
         cmd.right_speed = ramp_speed(req.base_speed, h - 45);
      end else if (h > 90 && h <= 135) begin
         cmd.left_speed = ramp_speed(req.base_speed, 135 - h);
      end else if (h > 135 && h <= 180) begin
         cmd.left_speed = ramp_speed(req.base_speed, h - 135);
      end
      cmd.left_dir_code  = left_fwd ? hdd_pkg::DIR_FWD : hdd_pkg::DIR_BACK;
      cmd.right_dir_code = right_fwd ? hdd_pkg::DIR_FWD : hdd_pkg::DIR_BACK;
      cmd.reversing      = !left_fwd && !right_fwd;
      return cmd;
   endfunction

   task automatic compare_field(string field, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   task automatic queue_request(int heading, int speed);
      drive_request_type req;
      req.heading    = hdd_pkg::HEADING_W'(heading);
      req.base_speed = hdd_pkg::SPEED_W'(speed);
      pending_requests.push_back(req);
   endtask

   // Driver. Inputs change on the falling edge only. A request stays on the
   // ports until the rising edge that takes it; then the next one follows at
   // once or after an idle gap, except through a quiet stretch of requests.
   always @(negedge clock) begin : driver
      drive_request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_requests.size() != 0 &&
             ((issued_count >= QUIET_FIRST && issued_count < QUIET_LAST) ||
              $urandom_range(99) >= IDLE_PCT)) begin
            next_req = pending_requests.pop_front();
            start          <= 1'b1;
            req_heading    <= next_req.heading;
            req_base_speed <= next_req.base_speed;
            issued_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. On each rising edge a taken request turns into a prediction
   // and a strobed result is checked against the oldest prediction. The
   // watchdog restarts whenever either side moves something.
   always @(posedge clock) begin : monitor
      drive_request_type taken_req;
      wheel_cmd_type     want;
      req_taken <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            taken_req.heading    = req_heading;
            taken_req.base_speed = req_base_speed;
            expected_cmds.push_back(predict_wheel_cmd(taken_req));
         end
         if (rsp_valid) begin
            if (expected_cmds.size() == 0) begin
               $error("result strobed with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_cmds.pop_front();
               compare_field("left_speed", want.left_speed, rsp_left_speed);
               compare_field("left_dir_code", want.left_dir_code, rsp_left_dir_code);
               compare_field("right_speed", want.right_speed, rsp_right_speed);
               compare_field("right_dir_code", want.right_dir_code, rsp_right_dir_code);
               compare_field("reversing", want.reversing, rsp_reversing);
            end
         end
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int pick;
      // Directed part: every sector edge at full speed, the unscaled
      // headings at and beyond -180 and beyond 180, zero speed, and speeds
      // around one sector width where the floor matters most.
      queue_request(-256, 65535);
      queue_request(-181, 65535);
      queue_request(-180, 65535);
      queue_request(-179, 65535);
      queue_request(-135, 65535);
      queue_request(-134, 65535);
      queue_request(-91, 65535);
      queue_request(-90, 65535);
      queue_request(-89, 65535);
      queue_request(-45, 65535);
      queue_request(-44, 65535);
      queue_request(0, 65535);
      queue_request(1, 65535);
      queue_request(45, 65535);
      queue_request(46, 65535);
      queue_request(90, 65535);
      queue_request(91, 65535);
      queue_request(135, 65535);
      queue_request(136, 65535);
      queue_request(180, 65535);
      queue_request(181, 65535);
      queue_request(255, 65535);
      queue_request(-1, 0);
      queue_request(-23, 44);
      queue_request(22, 46);

      // Random part: mostly headings in the stated range, some over the
      // whole 9-bit field, with speeds that are random, extreme or small.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         pick = $urandom_range(9);
         queue_request(pick < 8 ? int'($urandom_range(360)) - 180
                                : int'($urandom_range(511)) - 256,
                       pick == 0 ? ($urandom_range(1) ? 65535 : 0) :
                       pick == 1 ? int'($urandom_range(100)) :
                                   int'($urandom_range(65535)));
      end

      // Reset is released on a falling edge.
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start || expected_cmds.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_cmds.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
